>>> rtl/periodic_jitter_histogram_core_defines.svh
// ---------------------------------------------------------------------------
// periodic_jitter_histogram_core_defines.svh
// Assertion macros for the jitter histogram checker.
// ---------------------------------------------------------------------------
`ifndef PERIODIC_JITTER_HISTOGRAM_CORE_DEFINES_SVH
`define PERIODIC_JITTER_HISTOGRAM_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define PJH_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jitter histogram check failed");

// next-cycle implication, disabled in reset
`define PJH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jitter histogram check failed");

`endif

>>> rtl/pjh_pkg.sv
// ---------------------------------------------------------------------------
// pjh_pkg
// Types and constants shared by the jitter histogram core and its checker.
// ---------------------------------------------------------------------------
`default_nettype none

package pjh_pkg;

    localparam int TS_W      = 32;
    localparam int JIT_W     = 30;
    localparam int BIDX_W    = 6;
    localparam int BIN_OUT_W = 6;
    localparam int CNT_W     = 32;
    localparam int DEV_W     = 32;

    // jitter = (deviation + ROUND_BIAS) >> JIT_SHIFT
    localparam int ROUND_BIAS = 4;
    localparam int JIT_SHIFT  = 3;

    // operation codes
    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_READ   = 1'b1;

    // configuration port
    localparam int          APB_DATA_W   = 32;
    localparam int          PADDR_W      = 3;
    localparam int          REG_IDX_LSB  = 2;
    localparam logic        REG_PERIOD_A = 1'b0;
    localparam logic        REG_PERIOD_B = 1'b1;
    localparam logic [31:0] PERIOD_RESET = 32'd80000;

    typedef struct packed {
        logic              operation;
        logic              channel;
        logic [TS_W-1:0]   timestamp;
        logic [BIDX_W-1:0] bin_index;
    } cmd_t;

    typedef struct packed {
        logic                 channel_out;
        logic [JIT_W-1:0]     jitter;
        logic [BIN_OUT_W-1:0] bin;
        logic [CNT_W-1:0]     bin_count;
        logic [JIT_W-1:0]     max_jitter;
    } rsp_t;

endpackage

`default_nettype wire

>>> rtl/pjh_ram.sv
// ---------------------------------------------------------------------------
// pjh_ram
// Simple dual-port RAM, one write port, one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module pjh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read during write to the same address returns the old data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/periodic_jitter_histogram_core.sv
// ---------------------------------------------------------------------------
// periodic_jitter_histogram_core
// Two-channel jitter monitor: per-event deviation from the configured period,
// running maximum, and a per-channel histogram of jitter held in RAM.
// ---------------------------------------------------------------------------
//
// Port   Dir  Handshake                    Beat
// cmd    in   cmd_valid / cmd_stall        cmd_t  (record or bin read)
// rsp    out  rsp_valid / rsp_stall        rsp_t  (one per cmd beat)
// apb    in   psel, penable, pwrite, paddr period_a at 0x0, period_b at 0x4
//
// One beat per cycle while rsp_stall and the clear sweep allow; from accept to rsp_valid:
// two subtract stages, the rounding stage, the histogram RAM read, then the output register.
// Counts update by read-modify-write with a one-entry bypass of the last write.
// After reset all 2*BINS RAM entries are swept to zero with cmd_stall high.
// rsp_stall on a full output register freezes the whole pipe; cmd_stall
// follows it in the same cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module periodic_jitter_histogram_core
    import pjh_pkg::*;
#(
    parameter int BINS = 64
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cmd_valid,
    output logic                       cmd_stall,
    input  wire cmd_t                  cmd,
    output logic                       rsp_valid,
    input  wire logic                  rsp_stall,
    output rsp_t                       rsp,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [PADDR_W-1:0]    paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int DEPTH  = 2 * BINS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int BIN_W  = $clog2(BINS);

    localparam logic [BIN_W-1:0]  BIN_LAST  = BIN_W'(BINS - 1);
    localparam logic [ADDR_W-1:0] CH1_BASE  = ADDR_W'(BINS);
    localparam logic [ADDR_W-1:0] CLR_LAST  = ADDR_W'(DEPTH - 1);
    localparam logic [JIT_W-1:0]  JIT_BINS  = JIT_W'(BINS);

    typedef struct packed {
        logic              op;
        logic              ch;
        logic [BIDX_W-1:0] bidx;
        logic [TS_W-1:0]   diff;
    } s1_t;

    typedef struct packed {
        logic              op;
        logic              ch;
        logic [BIDX_W-1:0] bidx;
        logic [DEV_W-1:0]  dev;
    } s2_t;

    typedef struct packed {
        logic              op;
        logic              ch;
        logic [BIDX_W-1:0] bidx;
        logic [JIT_W-1:0]  jit;
    } s3_t;

    typedef struct packed {
        logic              op;
        logic              ch;
        logic [BIN_W-1:0]  bin;
        logic [ADDR_W-1:0] addr;
        logic [JIT_W-1:0]  jit;
    } s4_t;

    // configuration
    logic [TS_W-1:0] period_a_reg;
    logic [TS_W-1:0] period_b_reg;
    logic            cfg_we;

    // per-channel state
    logic [TS_W-1:0]  last_time_reg [2];
    logic [JIT_W-1:0] max_seen_reg  [2];

    // clear sweep
    logic              clr_busy_reg;
    logic [ADDR_W-1:0] clr_cnt_reg;

    // pipeline
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    s1_t  s1_reg, s1_next;
    s2_t  s2_reg, s2_next;
    s3_t  s3_reg, s3_next;
    s4_t  s4_reg, s4_next;

    // bypass of the last histogram write
    logic              fwd_valid_reg;
    logic [ADDR_W-1:0] fwd_addr_reg;
    logic [CNT_W-1:0]  fwd_data_reg;

    // output register
    logic rsp_valid_reg;
    rsp_t rsp_reg, rsp_next;

    logic              en;
    logic              accept;
    logic [TS_W-1:0]   prev_ts;
    logic [TS_W-1:0]   period_sel;
    logic [DEV_W:0]    round_sum;
    logic [BIN_W-1:0]  s3_bin;
    logic [ADDR_W-1:0] s3_addr;
    logic [CNT_W-1:0]  ram_rdata;
    logic [CNT_W-1:0]  cur_count;
    logic [CNT_W-1:0]  new_count;
    logic [JIT_W-1:0]  new_max;
    logic              hist_we;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [CNT_W-1:0]  ram_wdata;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;
    assign prdata = (paddr[REG_IDX_LSB] == REG_PERIOD_B) ? period_b_reg : period_a_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_a_reg <= PERIOD_RESET;
            period_b_reg <= PERIOD_RESET;
        end
        else if (cfg_we)
        begin
            if (paddr[REG_IDX_LSB] == REG_PERIOD_A)
            begin
                period_a_reg <= pwdata;
            end
            else
            begin
                period_b_reg <= pwdata;
            end
        end
    end

    // ------------------------------------------------------------------
    // flow control
    // ------------------------------------------------------------------
    assign en        = !rsp_valid_reg || !rsp_stall;
    assign cmd_stall = !en || clr_busy_reg;
    assign accept    = cmd_valid && !cmd_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ------------------------------------------------------------------
    // datapath
    // ------------------------------------------------------------------
    always_comb
    begin
        // stage 1: distance from the channel's previous timestamp
        prev_ts      = last_time_reg[cmd.channel];
        s1_next.op   = cmd.operation;
        s1_next.ch   = cmd.channel;
        s1_next.bidx = cmd.bin_index;
        s1_next.diff = (cmd.timestamp >= prev_ts) ? (cmd.timestamp - prev_ts)
                                                  : (prev_ts - cmd.timestamp);

        // stage 2: deviation from the period
        period_sel   = s1_reg.ch ? period_b_reg : period_a_reg;
        s2_next.op   = s1_reg.op;
        s2_next.ch   = s1_reg.ch;
        s2_next.bidx = s1_reg.bidx;
        s2_next.dev  = (s1_reg.diff >= period_sel) ? (s1_reg.diff - period_sel)
                                                   : (period_sel - s1_reg.diff);

        // stage 3: round to jitter units
        round_sum    = {1'b0, s2_reg.dev} + (DEV_W + 1)'(ROUND_BIAS);
        s3_next.op   = s2_reg.op;
        s3_next.ch   = s2_reg.ch;
        s3_next.bidx = s2_reg.bidx;
        s3_next.jit  = (s2_reg.op == OP_RECORD) ? round_sum[DEV_W:JIT_SHIFT] : '0;

        // stage 3 also picks the bin and issues the RAM read
        if (s3_reg.op == OP_RECORD)
        begin
            s3_bin = (s3_reg.jit >= JIT_BINS) ? BIN_LAST : s3_reg.jit[BIN_W-1:0];
        end
        else
        begin
            s3_bin = (32'(s3_reg.bidx) >= 32'(BINS)) ? BIN_LAST : BIN_W'(s3_reg.bidx);
        end
        s3_addr      = s3_reg.ch ? (ADDR_W'(s3_bin) + CH1_BASE) : ADDR_W'(s3_bin);
        s4_next.op   = s3_reg.op;
        s4_next.ch   = s3_reg.ch;
        s4_next.bin  = s3_bin;
        s4_next.addr = s3_addr;
        s4_next.jit  = s3_reg.jit;

        // stage 4: count update and result
        cur_count = (fwd_valid_reg && (fwd_addr_reg == s4_reg.addr)) ? fwd_data_reg
                                                                     : ram_rdata;
        new_count = (s4_reg.op == OP_RECORD) ? (cur_count + CNT_W'(1)) : cur_count;
        new_max   = (s4_reg.jit > max_seen_reg[s4_reg.ch]) ? s4_reg.jit
                                                           : max_seen_reg[s4_reg.ch];
        hist_we   = en && s4_valid_reg && (s4_reg.op == OP_RECORD);

        rsp_next.channel_out = s4_reg.ch;
        rsp_next.jitter      = s4_reg.jit;
        rsp_next.bin         = BIN_OUT_W'(s4_reg.bin);
        rsp_next.bin_count   = new_count;
        rsp_next.max_jitter  = new_max;

        // clear sweep owns the write port after reset
        if (clr_busy_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = hist_we;
            ram_waddr = s4_reg.addr;
            ram_wdata = new_count;
        end
    end

    pjh_ram #(
        .WIDTH (CNT_W),
        .DEPTH (DEPTH)
    ) u_hist_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (en),
        .raddr (s3_addr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg     <= 1'b1;
            clr_cnt_reg      <= '0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            s4_valid_reg     <= 1'b0;
            rsp_valid_reg    <= 1'b0;
            fwd_valid_reg    <= 1'b0;
            last_time_reg[0] <= '0;
            last_time_reg[1] <= '0;
            max_seen_reg[0]  <= '0;
            max_seen_reg[1]  <= '0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
                if (clr_cnt_reg == CLR_LAST)
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (en)
            begin
                s1_valid_reg  <= accept;
                s2_valid_reg  <= s1_valid_reg;
                s3_valid_reg  <= s2_valid_reg;
                s4_valid_reg  <= s3_valid_reg;
                rsp_valid_reg <= s4_valid_reg;
                fwd_valid_reg <= hist_we;
            end
            if (accept && (cmd.operation == OP_RECORD))
            begin
                last_time_reg[cmd.channel] <= cmd.timestamp;
            end
            if (hist_we)
            begin
                max_seen_reg[s4_reg.ch] <= new_max;
            end
        end
    end

    // ------------------------------------------------------------------
    // payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg       <= s1_next;
            s2_reg       <= s2_next;
            s3_reg       <= s3_next;
            s4_reg       <= s4_next;
            fwd_addr_reg <= s4_reg.addr;
            fwd_data_reg <= new_count;
            if (s4_valid_reg)
            begin
                rsp_reg <= rsp_next;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/pjh_checker.sv
// ---------------------------------------------------------------------------
// pjh_checker
// Port-level checks on the result channel of the jitter histogram core.
// ---------------------------------------------------------------------------
`default_nettype none
`include "periodic_jitter_histogram_core_defines.svh"

module pjh_checker
    import pjh_pkg::*;
#(
    parameter int BINS = 64
) (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic rsp_valid,
    input wire logic rsp_stall,
    input wire rsp_t rsp
);

    localparam logic [JIT_W-1:0]     JIT_BINS = JIT_W'(BINS);
    localparam logic [BIN_OUT_W-1:0] BIN_TOP  = BIN_OUT_W'(BINS - 1);

    // a stalled result beat holds
    `PJH_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

    // a nonzero jitter comes from a record, so the maximum covers it
    `PJH_ASSERT_NOW(a_max_covers, clk, rst_n, rsp_valid && (rsp.jitter != '0), rsp.max_jitter >= rsp.jitter)

    // in-range jitter lands in its own bin
    `PJH_ASSERT_NOW(a_bin_direct, clk, rst_n, rsp_valid && (rsp.jitter != '0) && (rsp.jitter < JIT_BINS), rsp.bin == rsp.jitter[BIN_OUT_W-1:0])

    // large jitter saturates in the last bin
    `PJH_ASSERT_NOW(a_bin_clamp, clk, rst_n, rsp_valid && (rsp.jitter >= JIT_BINS), rsp.bin == BIN_TOP)

endmodule

bind periodic_jitter_histogram_core pjh_checker #(.BINS(BINS)) u_pjh_checker (.*);

`default_nettype wire

>>> dv/tb_periodic_jitter_histogram_core.sv
// ---------------------------------------------------------------------------
// tb_periodic_jitter_histogram_core
// Self-checking bench for the two-channel jitter histogram core. A directed
// table (reset reads, period extremes, rounding and clamp edges) is followed
// by random periodic event streams under several period settings. Every rsp
// beat is checked field by field against an in-bench histogram tracker or the values
// typed into its table row; the period registers are read back over APB after each write.
// ---------------------------------------------------------------------------
module tb_periodic_jitter_histogram_core;
    timeunit 1ns;
    timeprecision 1ps;

    import pjh_pkg::*;

    localparam int BINS = 64;

    typedef enum logic {ROW_CMD, ROW_CFG} row_kind_t;
    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

    typedef struct {
        row_kind_t   kind;
        logic        reg_idx;
        logic [31:0] value;
        cmd_t        beat;
        bit          typed;
        rsp_t        want;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  cmd_valid = 1'b0;
    logic                  cmd_stall;
    cmd_t                  cmd = '0;
    logic                  rsp_valid;
    logic                  rsp_stall = 1'b0;
    rsp_t                  rsp;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [PADDR_W-1:0]    paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // tracker state
    logic [31:0] period_cfg [2];
    logic [31:0] last_stamp [2];
    logic [29:0] peak_jitter [2];
    logic [31:0] bin_counts [2*BINS];

    rsp_t      reports_due [$];
    stim_row_t rows [$];
    int        errors = 0;
    bit        hold_request = 1'b0;

    periodic_jitter_histogram_core #(.BINS(BINS)) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("periodic_jitter_histogram_core: mismatch");
        $finish;
    end

    // Expected report for one accepted beat; updates the tracker state.
    function automatic rsp_t account_event(input cmd_t c);
        logic [31:0] prev;
        logic [31:0] diff;
        logic [32:0] dev;
        logic [33:0] biased;
        logic [29:0] jit;
        logic [5:0]  b;
        int          slot;
        rsp_t        r;
        jit = '0;
        if (c.operation == OP_RECORD)
        begin
            prev = last_stamp[c.channel];
            diff = (c.timestamp > prev) ? c.timestamp - prev : prev - c.timestamp;
            dev  = (diff > period_cfg[c.channel])
                 ? {1'b0, diff} - {1'b0, period_cfg[c.channel]}
                 : {1'b0, period_cfg[c.channel]} - {1'b0, diff};
            biased = {1'b0, dev} + 34'd4;
            jit    = biased[32:3];
            if (jit > peak_jitter[c.channel])
                peak_jitter[c.channel] = jit;
            b    = (jit >= 30'(BINS)) ? 6'(BINS-1) : 6'(jit);
            slot = int'(c.channel) * BINS + int'(b);
            bin_counts[slot] = bin_counts[slot] + 32'd1;
            last_stamp[c.channel] = c.timestamp;
        end
        else
        begin
            b = c.bin_index;
        end
        slot          = int'(c.channel) * BINS + int'(b);
        r.channel_out = c.channel;
        r.jitter      = jit;
        r.bin         = b;
        r.bin_count   = bin_counts[slot];
        r.max_jitter  = peak_jitter[c.channel];
        return r;
    endfunction

    // Mostly well-formed periodic events near the configured period, plus
    // equal stamps, large deviations, random stamps and bin reads.
    function automatic cmd_t next_event();
        cmd_t c;
        int   pick;
        int   delta;
        c.channel   = 1'($urandom_range(0, 1));
        c.timestamp = $urandom;
        c.bin_index = 6'($urandom_range(0, 63));
        pick        = $urandom_range(0, 99);
        c.operation = (pick < 25) ? OP_READ : OP_RECORD;
        if (pick >= 25 && pick < 80)
        begin
            delta = int'($urandom_range(0, 1040)) - 520;
            c.timestamp = last_stamp[c.channel] + period_cfg[c.channel] + 32'(delta);
        end
        else if (pick >= 80 && pick < 85)
        begin
            c.timestamp = last_stamp[c.channel];
        end
        else if (pick >= 85 && pick < 92)
        begin
            delta = int'($urandom_range(8*BINS, 200000));
            if ($urandom_range(0, 1) == 1)
                delta = -delta;
            c.timestamp = last_stamp[c.channel] + period_cfg[c.channel] + 32'(delta);
        end
        return c;
    endfunction

    function automatic void add_cmd(input logic op, input logic ch, input logic [31:0] ts,
                                    input logic [5:0] bidx, input bit typed = 1'b0,
                                    input logic [29:0] wjit = '0, input logic [5:0] wbin = '0,
                                    input logic [31:0] wcnt = '0, input logic [29:0] wmax = '0);
        stim_row_t r;
        r.kind                = ROW_CMD;
        r.reg_idx             = REG_PERIOD_A;
        r.value               = '0;
        r.beat.operation      = op;
        r.beat.channel        = ch;
        r.beat.timestamp      = ts;
        r.beat.bin_index      = bidx;
        r.typed               = typed;
        r.want.channel_out    = ch;
        r.want.jitter         = wjit;
        r.want.bin            = wbin;
        r.want.bin_count      = wcnt;
        r.want.max_jitter     = wmax;
        rows.push_back(r);
    endfunction

    function automatic void add_cfg(input logic idx, input logic [31:0] val);
        stim_row_t r;
        r.kind    = ROW_CFG;
        r.reg_idx = idx;
        r.value   = val;
        r.beat    = '0;
        r.typed   = 1'b0;
        r.want    = '0;
        rows.push_back(r);
    endfunction

    function automatic logic [PADDR_W-1:0] reg_addr(input logic idx);
        return PADDR_W'(idx) << REG_IDX_LSB;
    endfunction

    task automatic send_beat(input cmd_t c, input bit typed, input rsp_t want);
        rsp_t predicted;
        cmd       <= c;
        cmd_valid <= 1'b1;
        do @(posedge clk); while (cmd_stall);
        predicted = account_event(c);
        reports_due.push_back(typed ? want : predicted);
    endtask

    task automatic drain_reports();
        cmd_valid <= 1'b0;
        wait (reports_due.size() == 0);
    endtask

    task automatic reg_write(input logic idx, input logic [31:0] val);
        paddr   <= reg_addr(idx);
        pwdata  <= val;
        pwrite  <= 1'b1;
        psel    <= 1'b1;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic reg_check(input logic idx, input logic [31:0] want);
        paddr   <= reg_addr(idx);
        pwrite  <= 1'b0;
        psel    <= 1'b1;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== want)
        begin
            errors++;
            $display("%0t: period reg %0d expected %h got %h", $time, idx, want, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // registers only change with the pipe empty
    task automatic apply_period(input logic idx, input logic [31:0] val);
        drain_reports();
        reg_write(idx, val);
        period_cfg[idx] = val;
        reg_check(idx, val);
    endtask

    task automatic run_random(input int n);
        int sent;
        int burst;
        int gap;
        sent = 0;
        while (sent < n)
        begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && sent < n; k++)
            begin
                send_beat(next_event(), 1'b0, '0);
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                cmd_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // receiver: switches between randomly chosen stall patterns; long hold on request
    initial
    begin
        stall_mode_t mode;
        int          mode_left;
        int          hold_left;
        int unsigned tick;
        mode      = STALL_NONE;
        mode_left = 0;
        hold_left = 0;
        tick      = 0;
        forever
        begin
            @(posedge clk);
            tick++;
            if (hold_left == 0 && hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = 300;
            end
            if (mode_left == 0)
            begin
                mode      = stall_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(32, 200);
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else
            begin
                case (mode)
                    STALL_NONE:  rsp_stall <= 1'b0;
                    STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: rsp_stall <= ($urandom_range(0, 9) < 6);
                    default:     rsp_stall <= ((tick % 16) < 5);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (reports_due.size() == 0)
            begin
                errors++;
                $display("%0t: rsp beat with nothing expected: %p", $time, rsp);
            end
            else
            begin
                want = reports_due.pop_front();
                if (rsp.channel_out !== want.channel_out)
                begin
                    errors++;
                    $display("%0t: channel_out expected %0d got %0d",
                             $time, want.channel_out, rsp.channel_out);
                end
                if (rsp.jitter !== want.jitter)
                begin
                    errors++;
                    $display("%0t: jitter expected %0d got %0d", $time, want.jitter, rsp.jitter);
                end
                if (rsp.bin !== want.bin)
                begin
                    errors++;
                    $display("%0t: bin expected %0d got %0d", $time, want.bin, rsp.bin);
                end
                if (rsp.bin_count !== want.bin_count)
                begin
                    errors++;
                    $display("%0t: bin_count expected %0d got %0d",
                             $time, want.bin_count, rsp.bin_count);
                end
                if (rsp.max_jitter !== want.max_jitter)
                begin
                    errors++;
                    $display("%0t: max_jitter expected %0d got %0d",
                             $time, want.max_jitter, rsp.max_jitter);
                end
            end
        end
    end

    initial
    begin
        period_cfg[0] = PERIOD_RESET;
        period_cfg[1] = PERIOD_RESET;
        foreach (last_stamp[i])
        begin
            last_stamp[i]  = '0;
            peak_jitter[i] = '0;
        end
        foreach (bin_counts[i])
            bin_counts[i] = '0;

        // reset state, equal stamps, first event against zero
        add_cmd(OP_READ,   1'b0, 32'd0,        6'd0,  1'b1, 30'd0,     6'd0,  32'd0, 30'd0);
        add_cmd(OP_READ,   1'b1, 32'hFFFF_FFFF, 6'd63, 1'b1, 30'd0,     6'd63, 32'd0, 30'd0);
        add_cmd(OP_RECORD, 1'b0, 32'd80000,    6'd0,  1'b1, 30'd0,     6'd0,  32'd1, 30'd0);
        add_cmd(OP_RECORD, 1'b0, 32'd80000,    6'd0,  1'b1, 30'd10000, 6'd63, 32'd1, 30'd10000);
        add_cmd(OP_RECORD, 1'b1, 32'd0,        6'd0,  1'b1, 30'd10000, 6'd63, 32'd1, 30'd10000);
        add_cmd(OP_RECORD, 1'b1, 32'hFFFF_FFFF, 6'd63);
        add_cmd(OP_RECORD, 1'b0, 32'd0,        6'd21);
        // rounding: deviation 4 rounds up, 3 rounds down
        add_cmd(OP_RECORD, 1'b0, 32'd80004,    6'd0);
        add_cmd(OP_RECORD, 1'b0, 32'd160007,   6'd0);
        // jitter 64 clamps to the last bin, 63 lands in it directly
        add_cmd(OP_RECORD, 1'b0, 32'd240515,   6'd42);
        add_cmd(OP_RECORD, 1'b0, 32'd321015,   6'd0);
        add_cmd(OP_READ,   1'b0, 32'hDEAD_BEEF, 6'd63);
        add_cmd(OP_READ,   1'b0, 32'd0,        6'd0);
        add_cmd(OP_READ,   1'b1, 32'd0,        6'd63);
        add_cmd(OP_READ,   1'b1, 32'h5555_AAAA, 6'd1);
        // period extremes
        add_cfg(REG_PERIOD_A, 32'd0);
        add_cfg(REG_PERIOD_B, 32'hFFFF_FFFF);
        add_cmd(OP_RECORD, 1'b0, 32'd321015,   6'd0);
        add_cmd(OP_RECORD, 1'b1, 32'hFFFF_FFFF, 6'd0, 1'b1, 30'h2000_0000, 6'd63, 32'd3,
                30'h2000_0000);
        add_cmd(OP_RECORD, 1'b0, 32'hFFFF_FFFF, 6'd0);
        add_cmd(OP_RECORD, 1'b1, 32'd0,        6'd0,  1'b1, 30'd0, 6'd0, 32'd1, 30'h2000_0000);
        add_cmd(OP_READ,   1'b1, 32'd0,        6'd63);
        add_cmd(OP_READ,   1'b0, 32'd0,        6'd63);
        add_cfg(REG_PERIOD_A, PERIOD_RESET);
        add_cfg(REG_PERIOD_B, PERIOD_RESET);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        reg_check(REG_PERIOD_A, PERIOD_RESET);
        reg_check(REG_PERIOD_B, PERIOD_RESET);

        foreach (rows[i])
        begin
            if (rows[i].kind == ROW_CFG)
            begin
                apply_period(rows[i].reg_idx, rows[i].value);
            end
            else
            begin
                send_beat(rows[i].beat, rows[i].typed, rows[i].want);
                if ($urandom_range(0, 3) == 0)
                begin
                    cmd_valid <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(posedge clk);
                end
            end
        end

        apply_period(REG_PERIOD_A, 32'd0);
        apply_period(REG_PERIOD_B, 32'hFFFF_FFFF);
        run_random(220);
        apply_period(REG_PERIOD_A, 32'hFFFF_FFFF);
        apply_period(REG_PERIOD_B, 32'd0);
        run_random(220);
        apply_period(REG_PERIOD_A, $urandom);
        apply_period(REG_PERIOD_B, $urandom);
        // receiver holds off while beats keep coming, so the pipe backs up
        hold_request = 1'b1;
        run_random(220);
        apply_period(REG_PERIOD_A, $urandom_range(0, 2000));
        apply_period(REG_PERIOD_B, $urandom_range(0, 200000));
        run_random(220);
        apply_period(REG_PERIOD_A, PERIOD_RESET);
        apply_period(REG_PERIOD_B, PERIOD_RESET);
        run_random(220);

        drain_reports();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("periodic_jitter_histogram_core: match");
        else
            $display("periodic_jitter_histogram_core: mismatch");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/pjh_pkg.sv
rtl/pjh_ram.sv
rtl/periodic_jitter_histogram_core.sv
rtl/pjh_checker.sv
dv/tb_periodic_jitter_histogram_core.sv
